@@ hdl/pal_pkg.sv @@
`default_nettype none

package pal_pkg;

  // Field widths of the stream items
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CAP_W      = 5;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ   = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_SH_RD,
    S_SH_WR,
    S_FIN,
    S_RESULT
  } state_e;

  // One finished result from the sequencer
  typedef struct packed {
    logic                is_full;
    logic                is_empty;
    logic [COUNT_W-1:0]  count;
    status_e             status;
    logic [VALUE_W-1:0]  read_value;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/pal_ram.sv @@
`default_nettype none

module pal_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ hdl/pal_seq.sv @@
`default_nettype none

module pal_seq #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned DATA_WIDTH  = 32,
  localparam int unsigned AW = $clog2(MAX_ENTRIES),
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Operation in
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire pal_pkg::mode_e                mode_i,
  input  wire logic [pal_pkg::POS_W-1:0]     position_i,
  input  wire logic [pal_pkg::VALUE_W-1:0]   value_i,
  input  wire logic [pal_pkg::CAP_W-1:0]     capacity_i,
  // Result out
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output pal_pkg::result_t                   res_o,
  // Entry memory
  output logic                               ram_we_o,
  output logic [AW-1:0]                      ram_waddr_o,
  output logic [DATA_WIDTH-1:0]              ram_wdata_o,
  output logic [AW-1:0]                      ram_raddr_o,
  input  wire logic [DATA_WIDTH-1:0]         ram_rdata_i
);

  // Compare width: holds position, count + 2 and capacity
  localparam int unsigned BW = (CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W;
  localparam int unsigned PW = BW + 2;

  pal_pkg::state_e  state_q, state_d;
  pal_pkg::mode_e   mode_q, mode_d;
  pal_pkg::status_e status_q, status_d;
  logic [pal_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [DATA_WIDTH-1:0]       word_q, word_d;
  logic [AW-1:0]               ptr_q, ptr_d;
  logic [CW-1:0]               count_q, count_d;
  logic [pal_pkg::VALUE_W-1:0] rd_q, rd_d;

  logic [PW-1:0] pos_w, cnt_w, ptr_w, cap_w, max_w, cap_eff;
  logic          pos_ok_rw, pos_ok_ins, list_full, shift_ins, shift_rem;
  logic          ins_last, rem_last, shift_last;
  logic [AW-1:0] pos_addr;

  // Position and capacity checks
  assign pos_w      = PW'(pos_q);
  assign cnt_w      = PW'(count_q);
  assign ptr_w      = PW'(ptr_q);
  assign cap_w      = PW'(capacity_i);
  assign max_w      = PW'(MAX_ENTRIES);
  assign cap_eff    = (cap_w > max_w) ? max_w : cap_w;
  assign pos_ok_rw  = (pos_w != '0) && (pos_w <= cnt_w);
  assign pos_ok_ins = (pos_w != '0) && (pos_w <= cnt_w + PW'(1));
  assign list_full  = cnt_w >= cap_eff;
  assign shift_ins  = pos_w <= cnt_w;
  assign shift_rem  = pos_w < cnt_w;
  assign ins_last   = ptr_w == pos_w;
  assign rem_last   = (ptr_w + PW'(2)) >= cnt_w;
  assign shift_last = (mode_q == pal_pkg::MODE_INSERT) ? ins_last : rem_last;
  assign pos_addr   = AW'(pos_w - PW'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pal_pkg::S_IDLE: begin
        if (in_valid_i) state_d = pal_pkg::S_EXEC;
      end
      pal_pkg::S_EXEC: begin
        unique case (mode_q)
          pal_pkg::MODE_READ: begin
            state_d = pos_ok_rw ? pal_pkg::S_RD_WAIT : pal_pkg::S_RESULT;
          end
          pal_pkg::MODE_WRITE: begin
            state_d = pal_pkg::S_RESULT;
          end
          pal_pkg::MODE_INSERT: begin
            priority if (list_full || !pos_ok_ins) state_d = pal_pkg::S_RESULT;
            else if (shift_ins)                    state_d = pal_pkg::S_SH_RD;
            else                                   state_d = pal_pkg::S_FIN;
          end
          pal_pkg::MODE_REMOVE: begin
            priority if (!pos_ok_rw) state_d = pal_pkg::S_RESULT;
            else if (shift_rem)      state_d = pal_pkg::S_SH_RD;
            else                     state_d = pal_pkg::S_FIN;
          end
          default: state_d = pal_pkg::S_RESULT;
        endcase
      end
      pal_pkg::S_RD_WAIT: state_d = pal_pkg::S_RESULT;
      pal_pkg::S_SH_RD:   state_d = pal_pkg::S_SH_WR;
      pal_pkg::S_SH_WR: begin
        state_d = shift_last ? pal_pkg::S_FIN : pal_pkg::S_SH_RD;
      end
      pal_pkg::S_FIN:     state_d = pal_pkg::S_RESULT;
      pal_pkg::S_RESULT: begin
        if (res_ready_i) state_d = pal_pkg::S_IDLE;
      end
      default: state_d = pal_pkg::S_IDLE;
    endcase
  end

  // Outputs, memory accesses and datapath
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = ptr_q;
    ram_wdata_o = ram_rdata_i;
    ram_raddr_o = pos_addr;
    mode_d      = mode_q;
    pos_d       = pos_q;
    word_d      = word_q;
    ptr_d       = ptr_q;
    count_d     = count_q;
    status_d    = status_q;
    rd_d        = rd_q;
    unique case (state_q)
      pal_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d   = mode_i;
          pos_d    = position_i;
          word_d   = DATA_WIDTH'($unsigned(value_i));
          status_d = pal_pkg::ST_DONE;
          rd_d     = '0;
        end
      end
      pal_pkg::S_EXEC: begin
        unique case (mode_q)
          pal_pkg::MODE_READ: begin
            if (!pos_ok_rw) status_d = pal_pkg::ST_BAD_POS;
          end
          pal_pkg::MODE_WRITE: begin
            if (pos_ok_rw) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = pos_addr;
              ram_wdata_o = word_q;
            end else begin
              status_d = pal_pkg::ST_BAD_POS;
            end
          end
          pal_pkg::MODE_INSERT: begin
            priority if (list_full) status_d = pal_pkg::ST_FULL;
            else if (!pos_ok_ins)   status_d = pal_pkg::ST_BAD_POS;
            else                    ptr_d    = AW'(count_q);
          end
          pal_pkg::MODE_REMOVE: begin
            if (pos_ok_rw) ptr_d    = pos_addr;
            else           status_d = pal_pkg::ST_BAD_POS;
          end
          default: status_d = pal_pkg::ST_BAD_POS;
        endcase
      end
      pal_pkg::S_RD_WAIT: begin
        rd_d = pal_pkg::VALUE_W'($signed(ram_rdata_i));
      end
      // Fetch the neighbor that moves into ptr
      pal_pkg::S_SH_RD: begin
        ram_raddr_o = (mode_q == pal_pkg::MODE_INSERT) ? ptr_q - AW'(1)
                                                       : ptr_q + AW'(1);
      end
      pal_pkg::S_SH_WR: begin
        ram_we_o = 1'b1;
        ptr_d    = (mode_q == pal_pkg::MODE_INSERT) ? ptr_q - AW'(1)
                                                    : ptr_q + AW'(1);
      end
      pal_pkg::S_FIN: begin
        if (mode_q == pal_pkg::MODE_INSERT) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = pos_addr;
          ram_wdata_o = word_q;
          count_d     = count_q + CW'(1);
        end else begin
          count_d     = count_q - CW'(1);
        end
      end
      pal_pkg::S_RESULT: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  // Result fields from the state after the operation
  assign res_o.read_value = rd_q;
  assign res_o.status     = status_q;
  assign res_o.count      = pal_pkg::COUNT_W'(count_q);
  assign res_o.is_empty   = (count_q == '0);
  assign res_o.is_full    = list_full;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pal_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Operation registers
  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    pos_q    <= pos_d;
    word_q   <= word_d;
    ptr_q    <= ptr_d;
    status_q <= status_d;
    rd_q     <= rd_d;
  end

endmodule

`default_nettype wire

@@ hdl/positional_array_list.sv @@
`default_nettype none

// Ordered list of words addressed by 1-based position, held in one
// synchronous RAM of MAX_ENTRIES words. Each item on the slave stream is a
// read, write, insert or remove; each gives exactly one result with status,
// count and empty/full flags. Items are handled one at a time by a
// sequencer in front of the RAM, and a result register lets the next item
// enter while the previous result waits. A write or a refused operation
// passes through an execute and a result state; a read adds a RAM read
// wait state. An insert moves count - position + 1 entries and a remove
// count - position, each with one RAM read and one RAM write state, then
// a final state stores an inserted word and updates the count. The RAM is
// not cleared after reset; only entries 1..count are returned or moved.
// The capacity register may be written at any time the list is idle.
module positional_array_list #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Operation stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [pal_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // position[7:0], value[39:8]
  input  wire logic [pal_pkg::MODE_W-1:0]        s_axis_tuser,  // mode[1:0]
  // Result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [pal_pkg::OUT_DATA_W-1:0]         m_axis_tdata,  // read_value[31:0],
                                                                // count[36:32],
                                                                // is_empty[37],
                                                                // is_full[38]
  output logic [pal_pkg::STATUS_W-1:0]           m_axis_tuser,  // status[1:0]
  // Capacity register write
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [pal_pkg::CAP_W-1:0]         cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);

  logic [pal_pkg::CAP_W-1:0] capacity_q;
  logic                      res_valid, res_ready;
  pal_pkg::result_t          res, out_q;
  logic                      out_valid_q;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0]     ram_wdata, ram_rdata;

  // Capacity register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= pal_pkg::CAP_RESET;
    end else if (cfg_valid_i) begin
      capacity_q <= cfg_data_i;
    end
  end

  pal_seq #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (pal_pkg::mode_e'(s_axis_tuser)),
    .position_i  (s_axis_tdata[pal_pkg::POS_W-1:0]),
    .value_i     (s_axis_tdata[pal_pkg::POS_W +: pal_pkg::VALUE_W]),
    .capacity_i  (capacity_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  pal_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  // Pack the result item
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {1'b0, out_q.is_full, out_q.is_empty, out_q.count,
                          out_q.read_value};

endmodule

`default_nettype wire

@@ sim/positional_array_list_tb.sv @@
`default_nettype none

module positional_array_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pal_pkg::*;

  localparam int unsigned MAX_ENTRIES  = 16;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned LONG_HOLD    = 250;
  localparam int unsigned PHASE_ITEMS  = 150;

  // List predictor plus queue of results still owed by the block
  class list_scoreboard;
    logic [VALUE_W-1:0] words [MAX_ENTRIES];
    int unsigned        n_words;
    logic [CAP_W-1:0]   capacity;
    result_t            pending_results[$];
    int unsigned        n_mismatch;

    function new();
      n_words  = 0;
      capacity = CAP_RESET;
      n_mismatch = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      capacity = c;
    endfunction

    function int unsigned effective_limit();
      return (capacity > MAX_ENTRIES) ? MAX_ENTRIES : capacity;
    endfunction

    // Apply one accepted operation and queue the result it must produce
    function void apply_op(mode_e m, logic [POS_W-1:0] pos, logic [VALUE_W-1:0] val);
      result_t     r;
      int unsigned lim;
      bit          in_list;
      lim     = effective_limit();
      in_list = (pos >= 1) && (pos <= n_words) && (pos <= MAX_ENTRIES);
      r.read_value = '0;
      r.status     = ST_DONE;
      case (m)
        MODE_READ: begin
          if (in_list) r.read_value = words[pos-1];
          else r.status = ST_BAD_POS;
        end
        MODE_WRITE: begin
          if (in_list) words[pos-1] = val;
          else r.status = ST_BAD_POS;
        end
        MODE_INSERT: begin
          // full is checked ahead of the position
          if (n_words >= lim) begin
            r.status = ST_FULL;
          end else if (pos < 1 || pos > n_words + 1) begin
            r.status = ST_BAD_POS;
          end else begin
            for (int i = n_words; i >= pos; i--) words[i] = words[i-1];
            words[pos-1] = val;
            n_words++;
          end
        end
        default: begin
          if (in_list) begin
            for (int i = pos - 1; i + 1 < n_words; i++) words[i] = words[i+1];
            n_words--;
          end else begin
            r.status = ST_BAD_POS;
          end
        end
      endcase
      r.count    = COUNT_W'(n_words);
      r.is_empty = (n_words == 0);
      r.is_full  = (n_words >= lim);
      pending_results.push_back(r);
    endfunction

    // Compare one result item with the oldest owed result
    function void check_result(logic [OUT_DATA_W-1:0] tdata, logic [STATUS_W-1:0] tuser);
      result_t want;
      bit      bad;
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: unexpected result item tdata=%h status=%0d", $time, tdata, tuser);
        return;
      end
      want = pending_results.pop_front();
      bad  = (tdata[31:0] !== want.read_value) || (tuser !== want.status) ||
             (tdata[36:32] !== want.count) || (tdata[37] !== want.is_empty) ||
             (tdata[38] !== want.is_full);
      if (bad) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: mismatch exp rd=%h st=%0d cnt=%0d emp=%0b full=%0b / got rd=%h st=%0d cnt=%0d emp=%0b full=%0b",
                   $time, want.read_value, want.status, want.count, want.is_empty,
                   want.is_full, tdata[31:0], tuser, tdata[36:32], tdata[37], tdata[38]);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // position[7:0], value[39:8]
  logic [MODE_W-1:0]     s_axis_tuser = '0;   // mode[1:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // read_value[31:0], count[36:32],
                                              // is_empty[37], is_full[38]
  logic [STATUS_W-1:0]   m_axis_tuser;        // status[1:0]
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CAP_W-1:0]      cfg_data_i = '0;

  list_scoreboard sb = new();

  bit src_idling  = 1'b1;
  bit sink_idling = 1'b1;
  bit long_hold_req = 1'b0;

  positional_array_list #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .DATA_WIDTH (VALUE_W)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Result check on every accepted item
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Result-side ready: random stalls, plus one long hold on request
  initial begin : result_sink
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else if (sink_idling && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Offer one operation and hold it until accepted
  task automatic send_item(input mode_e m, input logic [POS_W-1:0] p,
                           input logic [VALUE_W-1:0] v);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, p};
    s_axis_tuser  <= m;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.apply_op(m, p, v);
  endtask

  task automatic maybe_gap();
    if (src_idling && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Stop offering, wait for every owed result, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_capacity(c);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic op(input mode_e m, input logic [POS_W-1:0] p,
                    input logic [VALUE_W-1:0] v);
    maybe_gap();
    send_item(m, p, v);
  endtask

  // Edge cases: empty list, bad positions, front/middle/back, full refusals
  task automatic run_directed();
    op(MODE_READ,   8'd1,   32'h0);
    op(MODE_REMOVE, 8'd1,   32'h0);
    op(MODE_WRITE,  8'd1,   32'h1234_5678);
    op(MODE_INSERT, 8'd0,   32'h1111_1111);
    op(MODE_INSERT, 8'd2,   32'h2222_2222);
    op(MODE_INSERT, 8'd1,   32'h8000_0000);
    op(MODE_INSERT, 8'd2,   32'h7fff_ffff);
    op(MODE_INSERT, 8'd1,   32'hffff_ffff);
    op(MODE_INSERT, 8'd2,   32'h0000_0000);
    for (int i = 1; i <= 5; i++) op(MODE_READ, POS_W'(i), 32'h0);
    op(MODE_READ,   8'd255, 32'h0);
    op(MODE_WRITE,  8'd255, 32'haaaa_aaaa);
    op(MODE_WRITE,  8'd2,   32'ha5a5_a5a5);
    op(MODE_READ,   8'd2,   32'h0);
    op(MODE_REMOVE, 8'd4,   32'h0);
    op(MODE_REMOVE, 8'd1,   32'h0);
    op(MODE_READ,   8'd1,   32'h0);
    drain();
    // capacity exactly reached: refused even with a bad position
    write_capacity(5'd2);
    op(MODE_INSERT, 8'd1,   32'h5555_5555);
    op(MODE_INSERT, 8'd9,   32'h5555_5555);
    drain();
    // capacity below the count: entries kept, list counts as full
    write_capacity(5'd1);
    op(MODE_READ,   8'd2,   32'h0);
    op(MODE_REMOVE, 8'd2,   32'h0);
    op(MODE_INSERT, 8'd1,   32'h0);
    drain();
    // zero capacity: always full
    write_capacity(5'd0);
    op(MODE_REMOVE, 8'd1,   32'h0);
    op(MODE_INSERT, 8'd1,   32'h0);
    drain();
  endtask

  // Mostly well-formed operations around the live count, some noise
  task automatic run_random(input int unsigned n_items);
    mode_e            m;
    logic [POS_W-1:0] p;
    logic [VALUE_W-1:0] v;
    int unsigned      k;
    int unsigned      n;
    bit               grow;
    grow = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      n = sb.n_words;
      if ($urandom_range(0, 29) == 0) grow = !grow;
      v = $urandom();
      if ($urandom_range(0, 15) == 0) v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      if ($urandom_range(0, 99) < 8) begin
        m = mode_e'($urandom_range(0, 3));
        p = POS_W'($urandom_range(0, 255));
      end else begin
        k = $urandom_range(0, 99);
        if (k < 25) m = MODE_READ;
        else if (k < 45) m = MODE_WRITE;
        else if (k < (grow ? 85 : 60)) m = MODE_INSERT;
        else m = MODE_REMOVE;
        if (m == MODE_INSERT) p = POS_W'($urandom_range(1, n + 1));
        else p = POS_W'($urandom_range(1, (n == 0) ? 1 : n));
        // just past the end now and then
        if ($urandom_range(0, 19) == 0) p = POS_W'(n + 1 + $urandom_range(0, 1));
      end
      op(m, p, v);
    end
    drain();
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    write_capacity(5'd16);

    // fill up behind a long result-side hold
    long_hold_req = 1'b1;
    run_random(PHASE_ITEMS);
    write_capacity(5'd3);
    run_random(PHASE_ITEMS);
    src_idling  = 1'b0;
    sink_idling = 1'b0;
    write_capacity(5'd31);
    run_random(PHASE_ITEMS);
    src_idling  = 1'b1;
    sink_idling = 1'b1;
    write_capacity(5'd1);
    run_random(PHASE_ITEMS);
    write_capacity(CAP_W'($urandom_range(0, 31)));
    run_random(PHASE_ITEMS);
    write_capacity(5'd17);
    run_random(PHASE_ITEMS);
    write_capacity(CAP_W'($urandom_range(2, 16)));
    run_random(PHASE_ITEMS);
    // last stretch at full rate on both sides
    src_idling  = 1'b0;
    sink_idling = 1'b0;
    write_capacity(5'd16);
    run_random(PHASE_ITEMS);

    if (sb.n_mismatch == 0 && sb.pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
hdl/pal_pkg.sv
hdl/pal_ram.sv
hdl/pal_seq.sv
hdl/positional_array_list.sv
sim/positional_array_list_tb.sv
